@@ hdl/sjfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sjfs_pkg
// Types and constants shared by the shortest-job-first scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sjfs_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned ARR_W  = 16;
  localparam int unsigned BST_W  = 16;
  localparam int unsigned TIME_W = 22;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // one process record as it arrives
  typedef struct packed {
    logic [ID_W-1:0]  proc_id;
    logic [ARR_W-1:0] arrival_time;
    logic [BST_W-1:0] burst_len;
    logic             last;
  } in_word_t;

  // one scheduled slot
  typedef struct packed {
    logic [ID_W-1:0]   sched_id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic              last_out;
  } out_word_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

@@ hdl/sjfs_front.sv @@
// ----------------------------------------------------------------------------
// sjfs_front
// Takes process records, writes them to the record store in load order and
// hands a completed set (its record count) to the back end queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sjfs_front
  import sjfs_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire in_word_t                             in_data,
  input  wire logic                                 busy,
  output logic                                      wr_en,
  output logic [$clog2(MAX_PROCS)-1:0]              wr_addr,
  output in_word_t                                  wr_rec,
  output logic                                      push,
  output logic [$clog2(MAX_PROCS+1)-1:0]            push_cnt
);

  localparam int unsigned ADDR_W = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W  = $clog2(MAX_PROCS + 1);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;
  logic             room;

  // hold off new records while a set is queued or being scheduled
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign room     = cnt < CNT_W'(MAX_PROCS);

  // store write, records past capacity are dropped
  assign wr_en   = accept && room;
  assign wr_addr = cnt[ADDR_W-1:0];
  assign wr_rec  = in_data;

  assign cnt_next = room ? cnt + CNT_W'(1) : cnt;

  // a last-marked word closes the set, an empty set is dropped
  assign push     = accept && in_data.last && (cnt_next != '0);
  assign push_cnt = cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= in_data.last ? '0 : cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sjfs_queue.sv @@
// ----------------------------------------------------------------------------
// sjfs_queue
// Two-entry queue of set descriptors between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sjfs_queue #(
  parameter int unsigned W = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              valid,
  output logic [W-1:0]      data
);

  logic [W-1:0] slot [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;
  logic         do_push;
  logic         do_pop;

  assign do_push = push && (fill != 2'd2);
  assign do_pop  = pop && (fill != 2'd0);
  assign valid   = fill != 2'd0;
  assign data    = slot[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/sjfs_back.sv @@
// ----------------------------------------------------------------------------
// sjfs_back
// Record store and pick sequencer: for each slot it scans all stored records,
// keeps the least (burst, arrival, id) among those arrived and not yet run,
// and writes the slot to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sjfs_back
  import sjfs_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(MAX_PROCS)-1:0]         wr_addr,
  input  wire in_word_t                             wr_rec,
  input  wire logic                                 q_valid,
  input  wire logic [$clog2(MAX_PROCS+1)-1:0]       q_cnt,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output out_word_t                                 out_data
);

  localparam int unsigned ADDR_W = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W  = $clog2(MAX_PROCS + 1);

  // record store
  logic [ID_W-1:0]  mem_id    [MAX_PROCS];
  logic [ARR_W-1:0] mem_arr   [MAX_PROCS];
  logic [BST_W-1:0] mem_burst [MAX_PROCS];

  logic [MAX_PROCS-1:0] done;

  back_state_t state;
  back_state_t state_next;

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  emitted;
  logic [CNT_W-1:0]  issue_cnt;
  logic [TIME_W-1:0] cur_time;

  // read stage
  logic              rd_vld;
  logic              rd_done;
  logic [ADDR_W-1:0] rd_idx;
  logic [ID_W-1:0]   rd_id;
  logic [ARR_W-1:0]  rd_arr;
  logic [BST_W-1:0]  rd_burst;

  // running best and least pending arrival
  logic              best_vld;
  logic [ADDR_W-1:0] best_idx;
  logic [ID_W-1:0]   best_id;
  logic [ARR_W-1:0]  best_arr;
  logic [BST_W-1:0]  best_burst;
  logic [ARR_W-1:0]  min_arr;

  logic              issue;
  logic              scan_end;
  logic              elig;
  logic              better;
  logic              load_set;
  logic              restart;
  logic              gap_jump;
  logic              emit_fire;
  logic              last_slot;
  logic [TIME_W:0]   fin_sum;
  logic [TIME_W-1:0] fin;

  assign issue    = (state == ST_SCAN) && (issue_cnt != n);
  assign scan_end = (state == ST_SCAN) && (issue_cnt == n) && !rd_vld;
  assign elig     = rd_vld && !rd_done && ({{(TIME_W-ARR_W){1'b0}}, rd_arr} <= cur_time);
  assign better   = !best_vld ||
                    ({rd_burst, rd_arr, rd_id} < {best_burst, best_arr, best_id});

  // finish time saturates at the top of the time range
  assign fin_sum   = {1'b0, cur_time} + {{(TIME_W+1-BST_W){1'b0}}, best_burst};
  assign fin       = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
  assign last_slot = (emitted + CNT_W'(1)) == n;

  // sequencer next state and strobes
  always_comb begin
    state_next = state;
    load_set   = 1'b0;
    restart    = 1'b0;
    gap_jump   = 1'b0;
    emit_fire  = 1'b0;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          load_set   = 1'b1;
          restart    = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (best_vld) begin
          state_next = ST_EMIT;
        end else begin
          // nothing has arrived yet: move the clock to the next arrival
          gap_jump   = 1'b1;
          restart    = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit_fire = 1'b1;
          if (last_slot) begin
            q_pop      = 1'b1;
            state_next = ST_IDLE;
          end else begin
            restart    = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store write from the front end
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]    <= wr_rec.proc_id;
      mem_arr[wr_addr]   <= wr_rec.arrival_time;
      mem_burst[wr_addr] <= wr_rec.burst_len;
    end
  end

  // registered store read
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_id    <= mem_id[issue_cnt[ADDR_W-1:0]];
      rd_arr   <= mem_arr[issue_cnt[ADDR_W-1:0]];
      rd_burst <= mem_burst[issue_cnt[ADDR_W-1:0]];
      rd_idx   <= issue_cnt[ADDR_W-1:0];
      rd_done  <= done[issue_cnt[ADDR_W-1:0]];
    end
  end

  // scan control, best tracking and clock
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      best_vld  <= 1'b0;
      issue_cnt <= '0;
      emitted   <= '0;
      n         <= '0;
      cur_time  <= '0;
      done      <= '0;
      min_arr   <= '1;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (elig && better) begin
        best_vld   <= 1'b1;
        best_idx   <= rd_idx;
        best_id    <= rd_id;
        best_arr   <= rd_arr;
        best_burst <= rd_burst;
      end
      if (rd_vld && !rd_done && (rd_arr < min_arr)) begin
        min_arr <= rd_arr;
      end
      if (load_set) begin
        n        <= q_cnt;
        emitted  <= '0;
        cur_time <= '0;
        done     <= '0;
      end
      if (gap_jump) begin
        cur_time <= {{(TIME_W-ARR_W){1'b0}}, min_arr};
      end
      if (emit_fire) begin
        done[best_idx] <= 1'b1;
        cur_time       <= fin;
        emitted        <= emitted + CNT_W'(1);
      end
      if (restart) begin
        issue_cnt <= '0;
        best_vld  <= 1'b0;
        min_arr   <= '1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.sched_id    <= best_id;
      out_data.start_time  <= cur_time;
      out_data.finish_time <= fin;
      out_data.last_out    <= last_slot;
    end
  end

  // a slot never reruns a record already scheduled
  a_pick_not_done: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> !done[best_idx])
    else $error("picked record already scheduled");

  // an idle gap only happens when every pending arrival lies ahead
  a_gap_ahead: assert property (@(posedge clk) disable iff (rst)
    gap_jump |-> ({{(TIME_W-ARR_W){1'b0}}, min_arr} > cur_time))
    else $error("clock jump without a later arrival");

  // the slot count stays below the set size while a set is active
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (emitted < n))
    else $error("slot count ran past set size");

  // a clock jump always restarts the scan from the first record
  a_gap_then_pick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && !best_vld && gap_jump) |=> (state == ST_SCAN && issue_cnt == '0))
    else $error("rescan not started after clock jump");

endmodule

`default_nettype wire

@@ hdl/sjf_nonpreemptive_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_unit
// Non-preemptive shortest-job-first scheduler. Process records are loaded one
// word per cycle, while in_stall is low, until a last-marked word closes the
// set; records beyond MAX_PROCS are dropped. The set is then scheduled from
// the earliest arrival: each output word names the pending, arrived process
// with the least (burst, arrival, id), its start and its finish time
// (saturating at the top of the 22-bit range), and the final word of the set
// has last_out set. When nothing has arrived the clock jumps to the next
// arrival. Each output word costs one scan of the record store, one read per
// cycle, plus a pick and an emit step; a jump across an idle gap costs
// another scan (the first word of a set jumps too unless some record arrives
// at time zero), and an output stall holds the emit step.
// A new set is taken once the last word of the previous set has been produced.
// ----------------------------------------------------------------------------
`default_nettype none

module sjf_nonpreemptive_scheduler_unit
  import sjfs_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  localparam int unsigned ADDR_W = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W  = $clog2(MAX_PROCS + 1);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  in_word_t          wr_rec;
  logic              push;
  logic [CNT_W-1:0]  push_cnt;
  logic              q_valid;
  logic [CNT_W-1:0]  q_cnt;
  logic              q_pop;

  // record loading
  sjfs_front #(
    .MAX_PROCS (MAX_PROCS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .busy     (q_valid),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_rec   (wr_rec),
    .push     (push),
    .push_cnt (push_cnt)
  );

  // closed sets waiting for the scheduler
  sjfs_queue #(
    .W (CNT_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cnt),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_cnt)
  );

  // store and pick sequencer
  sjfs_back #(
    .MAX_PROCS (MAX_PROCS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_rec    (wr_rec),
    .q_valid   (q_valid),
    .q_cnt     (q_cnt),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ tb/sv/sjf_schedule_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sjf_schedule_checker
// Watches both word channels of the scheduler. Each accepted input word goes
// into a record store of its own while there is room. A last-marked word
// triggers a shortest-job-first schedule of the stored set, which is queued
// as expected output words. Accepted output words are compared field by field.
// ----------------------------------------------------------------------------

module sjf_schedule_checker
  import sjfs_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_word_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_word_t out_data,
  output int             fail_count,
  output int             slots_due
);

  // record store of the set being loaded
  logic [ID_W-1:0]  rec_id   [MAX_PROCS];
  logic [ARR_W-1:0] rec_arr  [MAX_PROCS];
  logic [BST_W-1:0] rec_bst  [MAX_PROCS];
  bit               rec_done [MAX_PROCS];
  int               rec_cnt;
  out_word_t        expected_slots [$];

  // pending record that has arrived by now with the least (burst, arrival, id)
  // strict compare keeps load order among identical keys
  function automatic int best_ready(input logic [TIME_W-1:0] now);
    int best;
    best = -1;
    for (int i = 0; i < rec_cnt; i++) begin
      if (!rec_done[i] && TIME_W'(rec_arr[i]) <= now &&
          (best < 0 ||
           {rec_bst[i], rec_arr[i], rec_id[i]} <
           {rec_bst[best], rec_arr[best], rec_id[best]}))
        best = i;
    end
    return best;
  endfunction

  // run the stored set in shortest-job-first order and queue its slots
  function automatic void build_schedule();
    logic [TIME_W-1:0] now;
    logic [TIME_W:0]   fin;
    int                pick;
    out_word_t         slot;
    now = TIME_MAX;
    for (int i = 0; i < rec_cnt; i++) begin
      rec_done[i] = 1'b0;
      if (TIME_W'(rec_arr[i]) < now) now = TIME_W'(rec_arr[i]);
    end
    for (int e = 0; e < rec_cnt; e++) begin
      pick = best_ready(now);
      if (pick < 0) begin
        // idle gap: jump to the earliest pending arrival
        now = TIME_MAX;
        for (int i = 0; i < rec_cnt; i++)
          if (!rec_done[i] && TIME_W'(rec_arr[i]) < now) now = TIME_W'(rec_arr[i]);
        pick = best_ready(now);
      end
      rec_done[pick] = 1'b1;
      fin = {1'b0, now} + (TIME_W+1)'(rec_bst[pick]);
      if (fin > {1'b0, TIME_MAX}) fin = {1'b0, TIME_MAX};
      slot.sched_id    = rec_id[pick];
      slot.start_time  = now;
      slot.finish_time = fin[TIME_W-1:0];
      slot.last_out    = (e == rec_cnt - 1);
      expected_slots   = {expected_slots, slot};
      now = fin[TIME_W-1:0];
    end
    rec_cnt = 0;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    int        errs;
    errs = 0;
    if (!rst) begin
      // input word: store it while there is room, schedule on last
      if (in_valid && !in_stall) begin
        if (rec_cnt < MAX_PROCS) begin
          rec_id[rec_cnt]  = in_data.proc_id;
          rec_arr[rec_cnt] = in_data.arrival_time;
          rec_bst[rec_cnt] = in_data.burst_len;
          rec_cnt++;
        end
        if (in_data.last) build_schedule();
      end
      // output word: compare with the oldest expected slot
      if (out_valid && !out_stall) begin
        if (expected_slots.size() == 0) begin
          $error("unexpected output word: sched_id %0d start %0d finish %0d last_out %0b",
                 out_data.sched_id, out_data.start_time, out_data.finish_time,
                 out_data.last_out);
          errs++;
        end else begin
          want = expected_slots.pop_front();
          if (out_data.sched_id !== want.sched_id) begin
            $error("sched_id: expected %0d, got %0d", want.sched_id, out_data.sched_id);
            errs++;
          end
          if (out_data.start_time !== want.start_time) begin
            $error("start_time: expected %0d, got %0d", want.start_time, out_data.start_time);
            errs++;
          end
          if (out_data.finish_time !== want.finish_time) begin
            $error("finish_time: expected %0d, got %0d", want.finish_time,
                   out_data.finish_time);
            errs++;
          end
          if (out_data.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_data.last_out);
            errs++;
          end
        end
      end
    end
    fail_count <= fail_count + errs;
    slots_due  <= expected_slots.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives process record sets into the shortest-job-first scheduler: a short
// directed run of corner cases, an over-capacity set, then random sets under
// three idling patterns. The checker predicts and compares every output word.
// ----------------------------------------------------------------------------

module testbench;
  import sjfs_pkg::*;

  localparam int unsigned MAX_PROCS    = 32;
  localparam int          RANDOM_WORDS = 150;

  // flavors of random record sets
  typedef enum int {
    MIX_CROWDED,
    MIX_WIDE,
    MIX_SPARSE
  } mix_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;

  int fail_count;
  int slots_due;
  int words_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int random_start;

  always #1 clk = ~clk;

  sjf_nonpreemptive_scheduler_unit #(
    .MAX_PROCS(MAX_PROCS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  sjf_schedule_checker #(
    .MAX_PROCS(MAX_PROCS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .slots_due (slots_due)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic in_word_t rec_word(input int id, input int arr, input int bst,
                                        input bit is_last);
    in_word_t w;
    w.proc_id      = ID_W'(id);
    w.arrival_time = ARR_W'(arr);
    w.burst_len    = BST_W'(bst);
    w.last         = is_last;
    return w;
  endfunction

  // send one word, with random idle cycles ahead of it
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // hold off the sender until every scheduled word has come out
  task automatic wait_for_schedule();
    in_valid <= 1'b0;
    @(posedge clk);
    while (slots_due != 0) @(posedge clk);
  endtask

  // one record set; some records repeat the previous one to force key ties
  task automatic send_set(input int n, input mix_t mix);
    in_word_t rec;
    rec = '0;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(99) >= 15) begin
        rec.proc_id = ID_W'($urandom_range(255));
        case (mix)
          MIX_CROWDED: begin
            rec.arrival_time = ARR_W'($urandom_range(15));
            rec.burst_len    = BST_W'($urandom_range(7));
          end
          MIX_WIDE: begin
            rec.arrival_time = ARR_W'($urandom_range(65535));
            rec.burst_len    = BST_W'($urandom_range(65535));
          end
          default: begin
            rec.arrival_time = ARR_W'($urandom_range(3000));
            rec.burst_len    = BST_W'($urandom_range(200));
          end
        endcase
      end
      rec.last = (i == n - 1);
      send_word(rec);
    end
  endtask

  // mostly small sets, now and then a full one
  task automatic send_random_set();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 70)      n = $urandom_range(6, 1);
    else if (r < 93) n = $urandom_range(16, 7);
    else             n = MAX_PROCS;
    send_set(n, mix_t'($urandom_range(2)));
  endtask

  initial begin
    send_idle_pct  = 36;
    recv_stall_pct = 47;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single records at the field extremes
    send_word(rec_word(0, 0, 0, 1'b1));
    send_word(rec_word(255, 65535, 65535, 1'b1));
    // idle gap between arrivals
    send_word(rec_word(1, 10, 5, 1'b0));
    send_word(rec_word(2, 100, 3, 1'b1));
    // identical keys run in load order, a lower id ahead of them
    send_word(rec_word(7, 5, 4, 1'b0));
    send_word(rec_word(7, 5, 4, 1'b0));
    send_word(rec_word(3, 5, 4, 1'b1));
    // ties on burst broken by arrival, then by id
    send_word(rec_word(10, 0, 9, 1'b0));
    send_word(rec_word(11, 2, 3, 1'b0));
    send_word(rec_word(13, 1, 3, 1'b0));
    send_word(rec_word(12, 1, 3, 1'b1));
    // late arrivals, zero and maximum bursts
    send_word(rec_word(200, 65535, 0, 1'b0));
    send_word(rec_word(201, 65534, 65535, 1'b0));
    send_word(rec_word(202, 65535, 0, 1'b1));
    // alternating bit patterns
    send_word(rec_word(8'hAA, 16'h5555, 16'hAAAA, 1'b0));
    send_word(rec_word(8'h55, 16'hAAAA, 16'h5555, 1'b1));
    wait_for_schedule();

    // more records than the store holds, last word among the dropped ones
    random_start = words_sent;
    send_set(MAX_PROCS + 3, MIX_CROWDED);

    while (words_sent < random_start + RANDOM_WORDS / 3) send_random_set();
    wait_for_schedule();
    send_idle_pct  = 47;
    recv_stall_pct = 36;
    while (words_sent < random_start + 2 * RANDOM_WORDS / 3) send_random_set();
    wait_for_schedule();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (words_sent < random_start + RANDOM_WORDS) send_random_set();

    wait_for_schedule();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && slots_due == 0) begin
      $display("** sjf_nonpreemptive_scheduler_unit: PASSED **");
    end else begin
      $display("** sjf_nonpreemptive_scheduler_unit: FAILED **");
    end
    $finish;
  end

  // run time limit
  initial begin
    #1_000_000;
    $display("** sjf_nonpreemptive_scheduler_unit: FAILED **");
    $finish;
  end

endmodule
